@@ sv/assert_macros.svh @@
// Assertion macros shared by the servo ramp RTL.
// Uses clk and rst_n from the including module; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MSR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define MSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MSR_ASSERT(lbl, cond)
`define MSR_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ sv/msr_pkg.sv @@
// Shared types and constants for the multi-servo ramp block.
// No dependencies.
`timescale 1ns / 1ps
package msr_pkg;
  localparam int MAX_SERVOS_DEF = 16;
  localparam int CHAN_LIMIT = 16;
  localparam int DIV_LONG = 49;
  localparam int DIV_CW = 6;
  // pulse scaling: |angle * span| < 2^27, divided by 1800 through a reciprocal
  localparam int PULSE_PW = 27;
  localparam logic [27:0] PULSE_RECIP = 28'd152709949;  // ceil(2^38 / 1800)
  localparam int PULSE_SHIFT = 38;
  localparam logic signed [17:0] MIRROR_BASE = 18'sd1800;
  localparam logic signed [16:0] DEG_ROUND = 17'sd5;
  localparam logic [15:0] DEG_RECIP = 16'd52429;  // ceil(2^19 / 10)
  localparam int DEG_SHIFT = 19;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0, CMD_TICK = 2'd1, CMD_DETACH = 2'd2, CMD_CALIB = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    GM_IDLE = 2'd0, GM_MOVING = 2'd1, GM_DETACHED = 2'd2
  } gmode_t;

  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  typedef struct packed {
    logic signed [15:0] cur;
    logic signed [15:0] goal;
    logic signed [15:0] sang;
    logic [31:0]        stime;
    logic [31:0]        len;
    logic [11:0]        pl;
    logic [11:0]        ph;
    logic signed [15:0] ll;
    logic signed [15:0] lh;
    logic signed [11:0] trim;
    logic               mir;
  } rec_t;

  localparam rec_t REC_RESET = '{
    cur: 16'sd0, goal: 16'sd0, sang: 16'sd0, stime: 32'd0, len: 32'd0,
    pl: 12'd150, ph: 12'd600, ll: 16'sd0, lh: 16'sd1800, trim: 12'sd0, mir: 1'b0
  };
endpackage

@@ sv/msr_mem.sv @@
// Per-channel state table: one synchronous memory, read data registered and valid in the cycle after rd_en.
// Entries never written read as the reset record (msr_pkg).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msr_mem #(
  parameter int DEPTH = msr_pkg::MAX_SERVOS_DEF,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output msr_pkg::rec_t     rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  msr_pkg::rec_t     wr_data
);
  msr_pkg::rec_t mem_r [DEPTH];
  msr_pkg::rec_t rdata_r;
  logic [DEPTH-1:0] vld_r;
  logic rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : msr_pkg::REC_RESET;

  // sequencer never reads an entry in the cycle it writes it
  `MSR_ASSERT(a_no_rw_same, !(rd_en && wr_en && rd_addr == wr_addr))
endmodule

@@ sv/msr_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle, 49-bit dividend.
// Uses msr_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [msr_pkg::DIV_LONG-1:0]  dividend,
  input  logic [31:0]                   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [msr_pkg::DIV_LONG-1:0]  quot,
  output logic                          rem_nz
);
  localparam int DW = msr_pkg::DIV_LONG;

  logic [DW-1:0] acc_r, acc_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [msr_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] rem_sh, rem_sub;

  always_comb begin
    rem_sh = {rem_r[31:0], acc_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = msr_pkg::DIV_CW'(msr_pkg::DIV_LONG);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub;
        acc_nxt = {acc_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        acc_nxt = {acc_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == msr_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = acc_r;
  assign rem_nz = |rem_r;

  `MSR_ASSERT_IMP(a_start_idle, start, !busy_r)
  `MSR_ASSERT_IMP(a_done_idle, done_r, !busy_r)
endmodule

@@ sv/multi_servo_timed_ramp.sv @@
// Multi-channel servo ramp table: one request at a time, state in msr_mem.
// Immediate move: result registered after S_RD, S_MCHK, S_DRV and S_DFIN in degree mode,
// with S_DST added in pulse mode; ramped move, calibrate end in S_MCHK or S_CCHK. Tick:
// S_SCAN and S_SCHK per ramping channel, then per ramping channel S_WALK, S_TCHK, S_TMUL,
// S_TST and the serial interpolation divide (skipped once done), drive states, result stalls.
// Reset (synchronous): control cleared, table entries read as defaults at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_servo_timed_ramp #(
  parameter int MAX_SERVOS = msr_pkg::MAX_SERVOS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_servo_index,
  input  logic signed [12:0] in_angle,
  input  logic [31:0]        in_duration_ms,
  input  logic [31:0]        in_now_ms,
  input  logic [11:0]        in_min_pulse,
  input  logic [11:0]        in_max_pulse,
  input  logic signed [12:0] in_min_angle,
  input  logic signed [12:0] in_max_angle,
  input  logic signed [11:0] in_angle_offset,
  input  logic               in_reversed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel,
  output logic [15:0]        out_drive_value,
  output logic               out_is_detached,
  output logic [1:0]         out_group_state,
  output logic               out_last
);
  localparam int NCH = (MAX_SERVOS < msr_pkg::CHAN_LIMIT) ? MAX_SERVOS : msr_pkg::CHAN_LIMIT;
  localparam int AW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CW = $clog2(NCH + 1);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001, S_RD   = 15'h0002, S_MCHK = 15'h0004, S_CCHK = 15'h0008,
    S_DET  = 15'h0010, S_SCAN = 15'h0020, S_SCHK = 15'h0040, S_WALK = 15'h0080,
    S_TCHK = 15'h0100, S_TMUL = 15'h0200, S_TST  = 15'h0400, S_TDIV = 15'h0800,
    S_DRV  = 15'h1000, S_DST  = 15'h2000, S_DFIN = 15'h4000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] act_r, act_nxt;
  logic mode_r, mode_nxt;
  msr_pkg::gmode_t gm_r, gm_nxt;
  logic [NCH-1:0] ramp_r, ramp_nxt, stop_r, stop_nxt;
  logic [CW-1:0] ch_r, ch_nxt, last_r, last_nxt;
  logic any_mid_r, any_mid_nxt, have_r, have_nxt;

  msr_pkg::cmd_t cmd_r;
  logic [3:0] idx_r;
  logic signed [12:0] ang_in_r, lo_in_r, hi_in_r;
  logic [31:0] dur_r, now_r;
  logic [11:0] pl_in_r, ph_in_r;
  logic signed [11:0] trim_in_r;
  logic rev_in_r;

  msr_pkg::rec_t rec_r, rec_nxt;
  logic signed [15:0] ang_r, ang_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic signed [49:0] prod_r, prod_nxt;
  logic [54:0] scl_r, scl_nxt;
  logic dneg_r, dneg_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [3:0] out_ch_r, out_ch_nxt;
  logic [15:0] out_drv_r, out_drv_nxt;
  logic out_det_r, out_det_nxt, out_last_r, out_last_nxt;
  logic [1:0] out_gs_r, out_gs_nxt;

  // memory and divider hookup
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  msr_pkg::rec_t rd_data, wr_data;
  logic div_start, div_busy, div_done, div_rnz;
  logic [msr_pkg::DIV_LONG-1:0] div_quot;

  logic in_acc, out_free, idx_ok, ch_end, mid, all_stop, prod_neg;
  logic [4:0] n_eff;
  logic [AW-1:0] cha, idxa;
  logic [31:0] elapsed;
  logic [49:0] prod_abs;
  logic signed [15:0] a16, c1, c2;
  logic signed [16:0] diff;
  logic signed [17:0] qs, a18;
  logic signed [18:0] f19;
  logic signed [16:0] x17;
  logic [15:0] xabs;
  logic signed [12:0] dspan;
  logic [15:0] drive, pq;
  logic [16:0] pdq;
  msr_pkg::rec_t mrec;

  msr_mem #(.DEPTH(NCH), .AW(AW)) u_mem (
    .clk(clk), .rst_n(rst_n), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  msr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(prod_abs[msr_pkg::DIV_LONG-1:0]), .divisor(rec_r.len),
    .busy(div_busy), .done(div_done), .quot(div_quot), .rem_nz(div_rnz)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign n_eff = (act_r > 5'(NCH)) ? 5'(NCH) : act_r;
  assign idx_ok = ({1'b0, idx_r} < n_eff);
  assign ch_end = (5'(ch_r) >= n_eff);
  assign cha = ch_r[AW-1:0];
  assign idxa = idx_r[AW-1:0];
  assign elapsed = now_r - rd_data.stime;
  assign mid = (elapsed < rd_data.len);
  assign prod_neg = prod_r[49];
  assign prod_abs = prod_neg ? 50'(-prod_r) : 50'(prod_r);

  always_comb begin
    // interpolation: start + num/len truncated toward zero
    diff = $signed({rec_r.goal[15], rec_r.goal}) - $signed({rec_r.sang[15], rec_r.sang});
    qs = prod_neg ? -$signed({1'b0, div_quot[16:0]}) : $signed({1'b0, div_quot[16:0]});
    f19 = 19'(rec_r.sang) + 19'(qs) - ((div_rnz && prod_neg) ? 19'sd1 : 19'sd0);
    if (div_rnz && f19 < 0) begin
      f19 = f19 + 19'sd1;
    end
    // clamp of move target
    a16 = 16'(ang_in_r);
    c1 = (a16 < rd_data.ll) ? rd_data.ll : a16;
    c2 = (c1 > rd_data.lh) ? rd_data.lh : c1;
    // drive arithmetic
    if (rec_r.mir) begin
      a18 = msr_pkg::MIRROR_BASE - 18'(ang_r) - 18'(rec_r.trim);
    end else begin
      a18 = 18'(ang_r) + 18'(rec_r.trim);
    end
    dspan = $signed({1'b0, rec_r.ph}) - $signed({1'b0, rec_r.pl});
    x17 = 17'(ang_r) + msr_pkg::DEG_ROUND;
    xabs = x17[16] ? 16'(-x17) : x17[15:0];
    // magnitude / 1800 from the reciprocal product
    pdq = scl_r[msr_pkg::PULSE_SHIFT+16:msr_pkg::PULSE_SHIFT];
    pq = prod_neg ? 16'(-pdq) : pdq[15:0];
    if (mode_r) begin
      drive = dneg_r ? -{3'b0, prod_r[msr_pkg::DEG_SHIFT+12:msr_pkg::DEG_SHIFT]}
                     : {3'b0, prod_r[msr_pkg::DEG_SHIFT+12:msr_pkg::DEG_SHIFT]};
    end else begin
      drive = {4'b0, rec_r.pl} + pq;
    end
    all_stop = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      if (i < int'(n_eff) && !stop_r[i] && i != int'(idx_r)) begin
        all_stop = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    mode_nxt = mode_r;
    gm_nxt = gm_r;
    ramp_nxt = ramp_r;
    stop_nxt = stop_r;
    ch_nxt = ch_r;
    last_nxt = last_r;
    any_mid_nxt = any_mid_r;
    have_nxt = have_r;
    rec_nxt = rec_r;
    ang_nxt = ang_r;
    elapsed_nxt = elapsed_r;
    prod_nxt = prod_r;
    scl_nxt = scl_r;
    dneg_nxt = dneg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ch_nxt = out_ch_r;
    out_drv_nxt = out_drv_r;
    out_det_nxt = out_det_r;
    out_last_nxt = out_last_r;
    out_gs_nxt = out_gs_r;
    rd_en = 1'b0;
    rd_addr = cha;
    wr_en = 1'b0;
    wr_addr = cha;
    wr_data = rec_r;
    div_start = 1'b0;
    mrec = rd_data;

    if (cfg_we) begin
      unique case (cfg_index)
        msr_pkg::CFG_ACTIVE: act_nxt = cfg_wdata;
        msr_pkg::CFG_MODE:   mode_nxt = cfg_wdata[0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (msr_pkg::cmd_t'(in_command) == msr_pkg::CMD_TICK) begin
            ch_nxt = '0;
            any_mid_nxt = 1'b0;
            have_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        rd_addr = idxa;
        if (!idx_ok || (cmd_r == msr_pkg::CMD_MOVE && ang_in_r == -13'sd1)) begin
          state_nxt = S_IDLE;
        end else if (cmd_r == msr_pkg::CMD_DETACH) begin
          state_nxt = S_DET;
        end else begin
          rd_en = 1'b1;
          state_nxt = (cmd_r == msr_pkg::CMD_MOVE) ? S_MCHK : S_CCHK;
        end
      end
      S_MCHK: begin
        wr_en = 1'b1;
        wr_addr = idxa;
        mrec.goal = c2;
        stop_nxt[idxa] = 1'b0;
        if (dur_r == 32'd0) begin
          mrec.cur = c2;
          ramp_nxt[idxa] = 1'b0;
          gm_nxt = msr_pkg::GM_IDLE;
          ang_nxt = c2;
          state_nxt = S_DRV;
        end else begin
          mrec.sang = rd_data.cur;
          mrec.len = dur_r;
          mrec.stime = now_r;
          ramp_nxt[idxa] = 1'b1;
          gm_nxt = msr_pkg::GM_MOVING;
          state_nxt = S_IDLE;
        end
        wr_data = mrec;
        rec_nxt = mrec;
      end
      S_CCHK: begin
        mrec.pl = pl_in_r;
        mrec.ph = ph_in_r;
        mrec.ll = 16'(lo_in_r);
        mrec.lh = 16'(hi_in_r);
        mrec.trim = trim_in_r;
        mrec.mir = rev_in_r;
        wr_en = 1'b1;
        wr_addr = idxa;
        wr_data = mrec;
        state_nxt = S_IDLE;
      end
      S_DET: begin
        if (out_free) begin
          ramp_nxt[idxa] = 1'b0;
          stop_nxt[idxa] = 1'b1;
          out_valid_nxt = 1'b1;
          out_ch_nxt = idx_r;
          out_drv_nxt = '0;
          out_det_nxt = 1'b1;
          out_last_nxt = 1'b1;
          out_gs_nxt = all_stop ? msr_pkg::GM_DETACHED : gm_r;
          if (all_stop) begin
            gm_nxt = msr_pkg::GM_DETACHED;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ch_end) begin
          gm_nxt = any_mid_r ? msr_pkg::GM_MOVING : msr_pkg::GM_IDLE;
          ch_nxt = '0;
          state_nxt = have_r ? S_WALK : S_IDLE;
        end else if (!ramp_r[cha]) begin
          ch_nxt = ch_r + 1'b1;
        end else begin
          rd_en = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        any_mid_nxt = any_mid_r || mid;
        have_nxt = 1'b1;
        last_nxt = ch_r;
        ch_nxt = ch_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_WALK: begin
        if (ch_end) begin
          state_nxt = S_IDLE;
        end else if (!ramp_r[cha]) begin
          ch_nxt = ch_r + 1'b1;
        end else begin
          rd_en = 1'b1;
          state_nxt = S_TCHK;
        end
      end
      S_TCHK: begin
        rec_nxt = rd_data;
        elapsed_nxt = elapsed;
        if (mid) begin
          state_nxt = S_TMUL;
        end else begin
          // ramp finished: land on the goal
          mrec.cur = rd_data.goal;
          wr_en = 1'b1;
          wr_data = mrec;
          ang_nxt = rd_data.goal;
          ramp_nxt[cha] = 1'b0;
          state_nxt = S_DRV;
        end
      end
      S_TMUL: begin
        prod_nxt = diff * $signed({1'b0, elapsed_r});
        state_nxt = S_TST;
      end
      S_TST: begin
        div_start = 1'b1;
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        if (div_done) begin
          mrec = rec_r;
          mrec.cur = f19[15:0];
          wr_en = 1'b1;
          wr_data = mrec;
          ang_nxt = f19[15:0];
          state_nxt = S_DRV;
        end
      end
      S_DRV: begin
        if (mode_r) begin
          prod_nxt = 50'(xabs) * 50'(msr_pkg::DEG_RECIP);
          dneg_nxt = x17[16];
          state_nxt = S_DFIN;
        end else begin
          prod_nxt = 50'($signed(a18[15:0])) * 50'(dspan);
          state_nxt = S_DST;
        end
      end
      S_DST: begin
        scl_nxt = 55'(prod_abs[msr_pkg::PULSE_PW-1:0]) * 55'(msr_pkg::PULSE_RECIP);
        state_nxt = S_DFIN;
      end
      S_DFIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_drv_nxt = drive;
          out_det_nxt = 1'b0;
          out_gs_nxt = gm_r;
          if (cmd_r == msr_pkg::CMD_TICK) begin
            out_ch_nxt = 4'(ch_r);
            out_last_nxt = (ch_r == last_r);
            ch_nxt = ch_r + 1'b1;
            state_nxt = S_WALK;
          end else begin
            out_ch_nxt = idx_r;
            out_last_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r <= 5'd16;
      mode_r <= 1'b0;
      gm_r <= msr_pkg::GM_IDLE;
      ramp_r <= '0;
      stop_r <= '0;
      ch_r <= '0;
      last_r <= '0;
      any_mid_r <= 1'b0;
      have_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_r <= act_nxt;
      mode_r <= mode_nxt;
      gm_r <= gm_nxt;
      ramp_r <= ramp_nxt;
      stop_r <= stop_nxt;
      ch_r <= ch_nxt;
      last_r <= last_nxt;
      any_mid_r <= any_mid_nxt;
      have_r <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      cmd_r <= msr_pkg::cmd_t'(in_command);
      idx_r <= in_servo_index;
      ang_in_r <= in_angle;
      dur_r <= in_duration_ms;
      now_r <= in_now_ms;
      pl_in_r <= in_min_pulse;
      ph_in_r <= in_max_pulse;
      lo_in_r <= in_min_angle;
      hi_in_r <= in_max_angle;
      trim_in_r <= in_angle_offset;
      rev_in_r <= in_reversed;
    end
    rec_r <= rec_nxt;
    ang_r <= ang_nxt;
    elapsed_r <= elapsed_nxt;
    prod_r <= prod_nxt;
    scl_r <= scl_nxt;
    dneg_r <= dneg_nxt;
    out_ch_r <= out_ch_nxt;
    out_drv_r <= out_drv_nxt;
    out_det_r <= out_det_nxt;
    out_last_r <= out_last_nxt;
    out_gs_r <= out_gs_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_drive_value = out_drv_r;
  assign out_is_detached = out_det_r;
  assign out_group_state = out_gs_r;
  assign out_last = out_last_r;

  `MSR_ASSERT_IMP(a_det_zero, out_valid_r && out_det_r, out_drv_r == 16'd0)
  `MSR_ASSERT_IMP(a_multi_tick, out_valid_r && !out_last_r,
                  out_gs_r != msr_pkg::GM_DETACHED)
  `MSR_ASSERT_IMP(a_div_wait, state_r == S_TDIV, div_busy || div_done)
endmodule
